// File: src/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared constants, types and the quarter-wave sine table for the voxel ray
// traversal block.
// ----------------------------------------------------------------------------
package vrt_pkg;

	localparam int GRID_SIDE_BITS = 5;
	localparam int FRACTION_BITS  = 8;
	localparam int ANGLE_BITS     = 10;

	// fixed field widths
	localparam int CELL_IN_W   = 5;
	localparam int ORIGIN_W    = 13;
	localparam int MAXD_W      = 14;
	localparam int MAXD_RESET  = 2048;

	localparam int ROW_W       = 2 * GRID_SIDE_BITS;
	localparam int ROW_BITS    = 1 << GRID_SIDE_BITS;
	localparam int ROW_COUNT   = 1 << ROW_W;
	localparam int ANGLE_QUARTER = 1 << (ANGLE_BITS - 2);

	// signed walk coordinate: room for the grid plus the farthest excursion
	localparam int WALK_SPAN   = (GRID_SIDE_BITS > (MAXD_W - FRACTION_BITS)) ?
		GRID_SIDE_BITS : (MAXD_W - FRACTION_BITS);
	localparam int CELL_W      = WALK_SPAN + 2;

	localparam int DIR_W       = 16;	// Q1.14 signed
	localparam int MAG_W       = 15;
	localparam int DVD_W       = 31;	// up to 2^30
	localparam int T_W         = 32;
	localparam logic [T_W-1:0] T_INF = '1;

	typedef logic [MAG_W-1:0] sine_tab_t [0:ANGLE_QUARTER];

	function automatic logic [MAG_W-1:0] quarter_sine(int unsigned r);
		longint unsigned x, x2, inner, outer, p, q;
		x     = longint'(r) << (18 - ANGLE_BITS);
		x2    = (x * x) >> 16;
		inner = 64'd42334 - ((x2 * 64'd4926) >> 16);
		outer = 64'd102944 - ((x2 * inner) >> 16);
		p     = (x * outer) >> 16;
		q     = (p + 64'd2) >> 2;
		if (q > 64'd16384) q = 64'd16384;
		return MAG_W'(q);
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t t;
		for (int i = 0; i <= ANGLE_QUARTER; i++) t[i] = quarter_sine(i);
		return t;
	endfunction

endpackage

// File: src/voxel_ray_traversal.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal
// Occupancy grid with a cell-by-cell ray walker (3-D DDA).
// ----------------------------------------------------------------------------
// A write beat (kind 0) sets or clears one cell of a 32x32x32 one-bit grid and
// returns nothing. A ray beat (kind 1) turns yaw/pitch into a Q1.14 direction
// through a quarter-wave sine table, forms the two direction products, then
// runs six serial divisions for the per-axis face distances and step sizes on
// one shared 1-bit-per-cycle divider. For each visited cell the walk first
// does a registered read of a 32-cell row of the occupancy RAM, then tests
// the bit and picks the next axis. The grid lives in a 1024 x 32 RAM with one
// write port and one registered read port; after reset a clearing pass writes
// one row per cycle until all 1024 rows are clear, during which no beat is
// taken (max_distance writes still land). Cells outside the grid read as
// empty. A result beat is held in an output register, so the next input beat
// can be taken while it waits.
module voxel_ray_traversal (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [vrt_pkg::MAXD_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [vrt_pkg::CELL_IN_W-1:0] cell_x,
	input  logic [vrt_pkg::CELL_IN_W-1:0] cell_y,
	input  logic [vrt_pkg::CELL_IN_W-1:0] cell_z,
	input  logic                          solid,
	input  logic [vrt_pkg::ORIGIN_W-1:0]  origin_x,
	input  logic [vrt_pkg::ORIGIN_W-1:0]  origin_y,
	input  logic [vrt_pkg::ORIGIN_W-1:0]  origin_z,
	input  logic [9:0]                    yaw,
	input  logic signed [9:0]             pitch,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic [vrt_pkg::CELL_IN_W-1:0] target_x,
	output logic [vrt_pkg::CELL_IN_W-1:0] target_y,
	output logic [vrt_pkg::CELL_IN_W-1:0] target_z,
	output logic [vrt_pkg::CELL_IN_W-1:0] before_x,
	output logic [vrt_pkg::CELL_IN_W-1:0] before_y,
	output logic [vrt_pkg::CELL_IN_W-1:0] before_z
);
	import vrt_pkg::*;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_WRRD  = 4'd2;
	localparam logic [3:0] S_WRWB  = 4'd3;
	localparam logic [3:0] S_ANG   = 4'd4;
	localparam logic [3:0] S_MUL   = 4'd5;
	localparam logic [3:0] S_DIVL  = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_RD    = 4'd8;
	localparam logic [3:0] S_DEC   = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	localparam sine_tab_t SINE_TAB = build_sine_tab();
	localparam int DIV_ITERS = DVD_W;
	localparam logic [2:0] LAST_OP = 3'd5;

	logic [3:0] state_q;

	// occupancy RAM: row = {z, y}, bit = x
	logic [ROW_BITS-1:0] occ_mem [0:ROW_COUNT-1];
	logic [ROW_BITS-1:0] rd_row_q;
	logic [ROW_W-1:0]    rd_addr;
	logic [ROW_W-1:0]    clr_q;

	logic [MAXD_W-1:0]   maxd_q;

	// write beat
	logic [ROW_W-1:0]          wrow_q;
	logic [GRID_SIDE_BITS-1:0] wbit_q;
	logic                      wval_q;

	// ray setup
	logic [ANGLE_BITS-1:0]   yaw_q, pit_q;
	logic [1:0]              ang_idx_q;
	logic signed [DIR_W-1:0] sin_q [0:3];	// sy, cy, sp, cp
	logic                    mul_idx_q;
	logic signed [DIR_W-1:0] dir_q [0:2];
	logic [ORIGIN_W-1:0]     org_q [0:2];

	// divider
	logic [2:0]          div_op_q;
	logic [4:0]          div_cnt_q;
	logic [MAG_W-1:0]    rem_q;
	logic [DVD_W-1:0]    quo_q;

	// walk
	logic [T_W-1:0]           tmax_q [0:2];
	logic [T_W-1:0]           tdel_q [0:2];
	logic signed [CELL_W-1:0] cur_q  [0:2];
	logic signed [CELL_W-1:0] prev_q [0:2];
	logic                     hit_q;

	// output register
	logic                 out_valid_q;
	logic                 hit_out_q;
	logic [CELL_IN_W-1:0] tgt_q [0:2];
	logic [CELL_IN_W-1:0] bef_q [0:2];

	// ---------------- sine lookup ----------------
	logic [ANGLE_BITS-1:0]   ang_a;
	logic [1:0]              ang_quad;
	logic [ANGLE_BITS-2:0]   ang_r, ang_ix;
	logic [MAG_W-1:0]        ang_mag;
	logic signed [DIR_W-1:0] ang_val;

	always_comb begin
		ang_a = (ang_idx_q[1] ? pit_q : yaw_q) +
			(ang_idx_q[0] ? ANGLE_BITS'(ANGLE_QUARTER) : '0);
		ang_quad = ang_a[ANGLE_BITS-1 -: 2];
		ang_r    = {1'b0, ang_a[ANGLE_BITS-3:0]};
		ang_ix   = ang_quad[0] ? ((ANGLE_BITS-1)'(ANGLE_QUARTER) - ang_r) : ang_r;
		ang_mag  = SINE_TAB[ang_ix];
		ang_val  = ang_quad[1] ? -$signed({1'b0, ang_mag}) : $signed({1'b0, ang_mag});
	end

	// ---------------- Q14 product, rounded half away ----------------
	logic signed [DIR_W-1:0] mul_a, mul_b, mul_res;
	logic [MAG_W-1:0]        mul_ma, mul_mb;
	logic [2*MAG_W-1:0]      mul_p;
	logic [MAG_W-1:0]        mul_m;

	always_comb begin
		mul_a   = mul_idx_q ? sin_q[1] : sin_q[3];
		mul_b   = mul_idx_q ? sin_q[3] : sin_q[0];
		mul_ma  = MAG_W'(mul_a < 0 ? -mul_a : mul_a);
		mul_mb  = MAG_W'(mul_b < 0 ? -mul_b : mul_b);
		mul_p   = mul_ma * mul_mb + (2*MAG_W)'(8192);
		mul_m   = MAG_W'(mul_p >> 14);
		mul_res = ((mul_a < 0) != (mul_b < 0)) ? -$signed({1'b0, mul_m})
			: $signed({1'b0, mul_m});
	end

	// ---------------- divider operands ----------------
	logic [1:0]               div_ax;
	logic signed [DIR_W-1:0]  div_d;
	logic [MAG_W-1:0]         div_ad;
	logic [FRACTION_BITS-1:0] div_frac;
	logic [FRACTION_BITS:0]   div_bd;
	logic [DVD_W-1:0]         div_dvd;
	logic [MAG_W:0]           rem_sh;
	logic                     rem_ge;

	always_comb begin
		div_ax   = div_op_q[2:1];
		div_d    = dir_q[div_ax];
		div_ad   = MAG_W'(div_d < 0 ? -div_d : div_d);
		div_frac = org_q[div_ax][FRACTION_BITS-1:0];
		div_bd   = (div_d < 0) ? {1'b0, div_frac}
			: ((FRACTION_BITS+1)'(1 << FRACTION_BITS) - {1'b0, div_frac});
		div_dvd  = div_op_q[0] ? DVD_W'(1 << 30)
			: (DVD_W'(div_bd) << (30 - FRACTION_BITS));
		rem_sh   = {rem_q, quo_q[DVD_W-1]};
		rem_ge   = rem_sh >= {1'b0, div_ad};
	end

	// ---------------- walk decision ----------------
	logic [1:0]               ax;
	logic [T_W-1:0]           limit;
	logic                     in_grid;
	logic                     cell_solid;
	logic signed [CELL_W-1:0] step_val;
	logic [GRID_SIDE_BITS-1:0] cur_bit;

	always_comb begin
		if (tmax_q[0] < tmax_q[1]) ax = (tmax_q[0] < tmax_q[2]) ? 2'd0 : 2'd2;
		else ax = (tmax_q[1] < tmax_q[2]) ? 2'd1 : 2'd2;
		limit    = T_W'(maxd_q) << (16 - FRACTION_BITS);
		in_grid  = (cur_q[0][CELL_W-1:GRID_SIDE_BITS] == '0) &&
			(cur_q[1][CELL_W-1:GRID_SIDE_BITS] == '0) &&
			(cur_q[2][CELL_W-1:GRID_SIDE_BITS] == '0);
		cur_bit    = cur_q[0][GRID_SIDE_BITS-1:0];
		cell_solid = in_grid && rd_row_q[cur_bit];
		step_val   = (dir_q[ax] < 0) ? -CELL_W'(1) : CELL_W'(1);
		rd_addr    = (state_q == S_WRRD) ? wrow_q
			: {cur_q[2][GRID_SIDE_BITS-1:0], cur_q[1][GRID_SIDE_BITS-1:0]};
	end

	// ---------------- RAM ----------------
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			occ_mem[clr_q] <= '0;
		end else if (state_q == S_WRWB) begin
			occ_mem[wrow_q] <= rd_row_q & ~(ROW_BITS'(1) << wbit_q) |
				(ROW_BITS'(wval_q) << wbit_q);
		end
		rd_row_q <= occ_mem[rd_addr];
	end

	// ---------------- control ----------------
	logic out_free;
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			maxd_q      <= MAXD_W'(MAXD_RESET);
			out_valid_q <= 1'b0;
			ang_idx_q   <= '0;
			mul_idx_q   <= 1'b0;
			div_op_q    <= '0;
			div_cnt_q   <= '0;
		end else begin
			if (cfg_we) maxd_q <= cfg_data;
			// S_DONE reloads the output register itself
			if (out_valid_q && out_ready && state_q != S_DONE) out_valid_q <= 1'b0;

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						if (!kind) state_q <= S_WRRD;
						else begin
							ang_idx_q <= '0;
							state_q   <= S_ANG;
						end
					end
				end
				S_WRRD: state_q <= S_WRWB;
				S_WRWB: state_q <= S_IDLE;
				S_ANG: begin
					ang_idx_q <= ang_idx_q + 1'b1;
					if (ang_idx_q == 2'd3) begin
						mul_idx_q <= 1'b0;
						state_q   <= S_MUL;
					end
				end
				S_MUL: begin
					mul_idx_q <= 1'b1;
					if (mul_idx_q) begin
						div_op_q <= '0;
						state_q  <= S_DIVL;
					end
				end
				S_DIVL: begin
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 5'(DIV_ITERS - 1)) begin
						div_op_q <= div_op_q + 1'b1;
						state_q  <= (div_op_q == LAST_OP) ? S_RD : S_DIVL;
					end
				end
				S_RD: state_q <= S_DEC;
				S_DEC: begin
					if (cell_solid || tmax_q[ax] > limit) state_q <= S_DONE;
					else state_q <= S_RD;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				wrow_q <= {GRID_SIDE_BITS'(cell_z), GRID_SIDE_BITS'(cell_y)};
				wbit_q <= GRID_SIDE_BITS'(cell_x);
				wval_q <= solid;
				yaw_q  <= ANGLE_BITS'(yaw);
				pit_q  <= ANGLE_BITS'(pitch);
				org_q[0] <= origin_x;
				org_q[1] <= origin_y;
				org_q[2] <= origin_z;
				cur_q[0] <= CELL_W'(origin_x >> FRACTION_BITS);
				cur_q[1] <= CELL_W'(origin_y >> FRACTION_BITS);
				cur_q[2] <= CELL_W'(origin_z >> FRACTION_BITS);
				prev_q[0] <= CELL_W'(origin_x >> FRACTION_BITS);
				prev_q[1] <= CELL_W'(origin_y >> FRACTION_BITS);
				prev_q[2] <= CELL_W'(origin_z >> FRACTION_BITS);
				hit_q <= 1'b0;
			end
			S_ANG: sin_q[ang_idx_q] <= ang_val;
			S_MUL: begin
				dir_q[1] <= -sin_q[2];
				if (mul_idx_q) dir_q[2] <= mul_res;
				else dir_q[0] <= mul_res;
			end
			S_DIVL: begin
				rem_q <= '0;
				quo_q <= div_dvd;
			end
			S_DIV: begin
				if (div_cnt_q == 5'(DIV_ITERS - 1)) begin
					// last bit lands straight in the axis registers
					if (div_op_q[0]) tdel_q[div_ax] <= (div_d == 0) ? T_INF
						: T_W'({quo_q[DVD_W-2:0], rem_ge});
					else tmax_q[div_ax] <= (div_d == 0) ? T_INF
						: T_W'({quo_q[DVD_W-2:0], rem_ge});
				end else begin
					rem_q <= rem_ge ? MAG_W'(rem_sh - {1'b0, div_ad}) : MAG_W'(rem_sh);
					quo_q <= {quo_q[DVD_W-2:0], rem_ge};
				end
			end
			S_DEC: begin
				if (cell_solid) begin
					hit_q <= 1'b1;
				end else if (tmax_q[ax] > limit) begin
					// miss: report the origin cell twice
					for (int i = 0; i < 3; i++) begin
						cur_q[i]  <= CELL_W'(org_q[i] >> FRACTION_BITS);
						prev_q[i] <= CELL_W'(org_q[i] >> FRACTION_BITS);
					end
				end else begin
					for (int i = 0; i < 3; i++) prev_q[i] <= cur_q[i];
					cur_q[ax]  <= cur_q[ax] + step_val;
					tmax_q[ax] <= tmax_q[ax] + tdel_q[ax];
				end
			end
			S_DONE: begin
				if (out_free) begin
					hit_out_q <= hit_q;
					for (int i = 0; i < 3; i++) begin
						tgt_q[i] <= CELL_IN_W'(cur_q[i]);
						bef_q[i] <= CELL_IN_W'(prev_q[i]);
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_out_q;
	assign target_x  = tgt_q[0];
	assign target_y  = tgt_q[1];
	assign target_z  = tgt_q[2];
	assign before_x  = bef_q[0];
	assign before_y  = bef_q[1];
	assign before_z  = bef_q[2];

endmodule

// File: src/vrt_checker.sv
// ----------------------------------------------------------------------------
// vrt_checker
// Port-level checks for the voxel ray traversal block, bound to the top level.
// ----------------------------------------------------------------------------
module vrt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          kind,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          hit,
	input logic [vrt_pkg::CELL_IN_W-1:0] target_x,
	input logic [vrt_pkg::CELL_IN_W-1:0] target_y,
	input logic [vrt_pkg::CELL_IN_W-1:0] target_z,
	input logic [vrt_pkg::CELL_IN_W-1:0] before_x,
	input logic [vrt_pkg::CELL_IN_W-1:0] before_y,
	input logic [vrt_pkg::CELL_IN_W-1:0] before_z
);
	import vrt_pkg::*;

	// one item at a time: busy right after a beat is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on back-to-back cycles");

	// a grid write raises no result beat right after it is taken
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !kind |=> !$rose(out_valid))
		else $error("result after grid write");

	// a miss reports the same cell as both target and before
	a_miss_same: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> target_x == before_x && target_y == before_y &&
			target_z == before_z)
		else $error("miss with differing cells");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(target_x))
		else $error("stalled result dropped or changed");

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.kind      (kind),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.hit       (hit),
	.target_x  (target_x),
	.target_y  (target_y),
	.target_z  (target_z),
	.before_x  (before_x),
	.before_y  (before_y),
	.before_z  (before_z)
);
